### hw/rtl/gbmm_pkg.sv
package gbmm_pkg;

    typedef struct packed {
        logic cell_free;
        logic last_cell;
    } in_t;

    typedef struct packed {
        logic [9:0]  matching_size;
        logic [10:0] independent_size;
    } out_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLS = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET     = 6'd32;

    // next direction to try; DIR_DONE means all four were tried
    typedef enum logic [2:0] {
        DIR_RIGHT = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DONE  = 3'd4
    } dir_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_ROOT,
        S_ROOT_CHK,
        S_NB,
        S_NB_CHK,
        S_POP,
        S_FLIP,
        S_FLIP_WAIT,
        S_ADV,
        S_DONE
    } state_t;

endpackage

### hw/rtl/grid_bipartite_max_matching_unit.sv
// sequence: after the last cell the run clears every table entry, then checks
// each root cell, probes its neighbors on and off the grid, pops frames or flips
// path steps, and then registers the result
// throughput: one cell per cycle while loading and no result waits, one grid per run; the single
// memory port of each table sets the per-step cost of the search
// reset: registers return to 32 rows and 32 columns, load state and output clear
module grid_bipartite_max_matching_unit #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  gbmm_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output gbmm_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gbmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gbmm_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);
    localparam int STK   = CELLS / 2 + 1;
    localparam int SAW   = $clog2(STK);
    localparam int SPW   = $clog2(STK + 1);

    typedef struct packed {
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        logic [AW-1:0] idx;
        dir_t          dir;
    } frame_t;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        logic [AW-1:0] idx;
    } mate_t;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] tag;
    } mark_t;

    // memories
    logic   free_mem [CELLS];
    mate_t  part_mem [CELLS];
    mark_t  vis_mem  [CELLS];
    frame_t stk_mem  [STK];

    logic   free_rdata;
    mate_t  part_rdata;
    mark_t  vis_rdata;
    frame_t stk_rdata;

    // control registers
    state_t               state_reg, state_next;
    logic [CFG_DATA_W-1:0] grid_rows_reg, grid_rows_next;
    logic [CFG_DATA_W-1:0] grid_cols_reg, grid_cols_next;
    logic [IW-1:0]        load_pos_reg, load_pos_next;
    logic [IW-1:0]        free_count_reg, free_count_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic                 out_valid_reg, out_valid_next;

    // datapath registers
    logic [DRW-1:0] rows_reg, rows_next;
    logic [DCW-1:0] cols_reg, cols_next;
    logic [IW-1:0]  total_reg, total_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [IW-1:0]  u_reg, u_next;
    logic [RW-1:0]  ur_reg, ur_next;
    logic [CW-1:0]  uc_reg, uc_next;
    logic [AW-1:0]  root_reg, root_next;
    frame_t         top_reg, top_next;
    logic [AW-1:0]  v_idx_reg, v_idx_next;
    logic [IW-1:0]  match_reg, match_next;
    out_t           out_data_reg, out_data_next;

    logic           in_accept, out_accept;
    logic [DRW-1:0] rows_cur;
    logic [DCW-1:0] cols_cur;
    logic [IW-1:0]  limit_cur;
    logic           nb_ok;
    logic [AW-1:0]  nb_idx;
    logic [AW-1:0]  flip_idx;
    logic           root_ok, v_take;

    logic           free_we;
    logic [AW-1:0]  free_waddr, free_raddr;
    logic           part_we;
    logic [AW-1:0]  part_waddr;
    mate_t          part_wdata;
    logic           vis_we;
    logic [AW-1:0]  vis_waddr;
    mark_t          vis_wdata;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign cfg_ready  = 1'b1;

    // clamp the register values into the supported range
    always_comb
    begin
        if (grid_rows_reg == '0)
            rows_cur = DRW'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            rows_cur = DRW'(MAX_ROWS);
        else
            rows_cur = DRW'(grid_rows_reg);
        if (grid_cols_reg == '0)
            cols_cur = DCW'(1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            cols_cur = DCW'(MAX_COLS);
        else
            cols_cur = DCW'(grid_cols_reg);
        limit_cur = IW'(rows_cur) * IW'(cols_cur);
    end

    // neighbor of the top frame in its next direction
    always_comb
    begin
        nb_ok  = 1'b0;
        nb_idx = top_reg.idx;
        case (top_reg.dir)
            DIR_RIGHT:
            begin
                nb_ok  = (DCW'(top_reg.c) + DCW'(1)) < cols_reg;
                nb_idx = top_reg.idx + AW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok  = top_reg.c != '0;
                nb_idx = top_reg.idx - AW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok  = (DRW'(top_reg.r) + DRW'(1)) < rows_reg;
                nb_idx = top_reg.idx + AW'(cols_reg);
            end
            DIR_UP:
            begin
                nb_ok  = top_reg.r != '0;
                nb_idx = top_reg.idx - AW'(cols_reg);
            end
            default:
            begin
                nb_ok  = 1'b0;
                nb_idx = top_reg.idx;
            end
        endcase
    end

    // neighbor a stacked frame last chose (its direction minus one)
    always_comb
    begin
        case (stk_rdata.dir)
            DIR_LEFT: flip_idx = stk_rdata.idx + AW'(1);
            DIR_DOWN: flip_idx = stk_rdata.idx - AW'(1);
            DIR_UP:   flip_idx = stk_rdata.idx + AW'(cols_reg);
            default:  flip_idx = stk_rdata.idx - AW'(cols_reg);
        endcase
    end

    // cells at or past the load position were not loaded in this grid
    assign root_ok = free_rdata && (u_reg < load_pos_reg) && (ur_reg[0] ^ uc_reg[0]);
    assign v_take  = free_rdata && (IW'(v_idx_reg) < load_pos_reg)
                     && !(vis_rdata.valid && vis_rdata.tag == root_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
                if (in_accept && in_data.last_cell)
                    state_next = S_CLEAR;
            S_CLEAR:
                if (clr_reg == AW'(CELLS - 1))
                    state_next = S_ROOT;
            S_ROOT:
                state_next = (u_reg >= total_reg) ? S_DONE : S_ROOT_CHK;
            S_ROOT_CHK:
                state_next = root_ok ? S_NB : S_ADV;
            S_NB:
                if (top_reg.dir == DIR_DONE)
                    state_next = (sp_reg == SPW'(1)) ? S_ADV : S_POP;
                else if (nb_ok)
                    state_next = S_NB_CHK;
            S_NB_CHK:
                state_next = (v_take && !part_rdata.valid) ? S_FLIP : S_NB;
            S_POP:
                state_next = S_NB;
            S_FLIP:
                state_next = (sp_reg == SPW'(1)) ? S_ADV : S_FLIP_WAIT;
            S_FLIP_WAIT:
                state_next = S_FLIP;
            S_ADV:
                state_next = S_ROOT;
            S_DONE:
                state_next = S_LOAD;
            default:
                state_next = S_LOAD;
        endcase
    end

    // handshake and memory controls
    always_comb
    begin
        in_stall   = (state_reg != S_LOAD) || out_valid_reg;
        free_we    = in_accept && (load_pos_reg < limit_cur);
        free_waddr = AW'(load_pos_reg);
        free_raddr = (state_reg == S_ROOT) ? AW'(u_reg) : nb_idx;
        part_we    = (state_reg == S_CLEAR) || (state_reg == S_FLIP);
        part_waddr = (state_reg == S_CLEAR) ? clr_reg : v_idx_reg;
        part_wdata = (state_reg == S_CLEAR) ? mate_t'('0)
                     : mate_t'{valid: 1'b1, r: top_reg.r, c: top_reg.c, idx: top_reg.idx};
        vis_we     = (state_reg == S_CLEAR) || ((state_reg == S_NB_CHK) && v_take);
        vis_waddr  = (state_reg == S_CLEAR) ? clr_reg : v_idx_reg;
        vis_wdata  = (state_reg == S_CLEAR) ? mark_t'('0)
                     : mark_t'{valid: 1'b1, tag: root_reg};
        stk_we     = (state_reg == S_NB_CHK) && v_take && part_rdata.valid
                     && (sp_reg < SPW'(STK));
        stk_waddr  = SAW'(sp_reg - SPW'(1));
        stk_raddr  = SAW'(sp_reg - SPW'(2));
    end

    // datapath next values
    always_comb
    begin
        grid_rows_next  = grid_rows_reg;
        grid_cols_next  = grid_cols_reg;
        load_pos_next   = load_pos_reg;
        free_count_next = free_count_reg;
        sp_next         = sp_reg;
        out_valid_next  = out_valid_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        total_next      = total_reg;
        clr_next        = clr_reg;
        u_next          = u_reg;
        ur_next         = ur_reg;
        uc_next         = uc_reg;
        root_next       = root_reg;
        top_next        = top_reg;
        v_idx_next      = v_idx_reg;
        match_next      = match_reg;
        out_data_next   = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_next = cfg_data;
                REG_GRID_COLS: grid_cols_next = cfg_data;
                default: ;
            endcase
        end
        if (out_accept)
            out_valid_next = 1'b0;

        case (state_reg)
            S_LOAD:
                if (in_accept)
                begin
                    if (free_we)
                    begin
                        load_pos_next   = load_pos_reg + IW'(1);
                        free_count_next = free_count_reg + IW'(in_data.cell_free);
                    end
                    if (in_data.last_cell)
                    begin
                        rows_next  = rows_cur;
                        cols_next  = cols_cur;
                        total_next = limit_cur;
                        clr_next   = '0;
                        u_next     = '0;
                        ur_next    = '0;
                        uc_next    = '0;
                        match_next = '0;
                    end
                end
            S_CLEAR:
                clr_next = clr_reg + AW'(1);
            S_ROOT_CHK:
                if (root_ok)
                begin
                    top_next  = '{r: ur_reg, c: uc_reg, idx: AW'(u_reg), dir: DIR_RIGHT};
                    root_next = AW'(u_reg);
                    sp_next   = SPW'(1);
                end
            S_NB:
                if (top_reg.dir == DIR_DONE)
                begin
                    if (sp_reg != SPW'(1))
                        sp_next = sp_reg - SPW'(1);
                end
                else
                begin
                    top_next.dir = dir_t'(top_reg.dir + 3'd1);
                    v_idx_next   = nb_idx;
                end
            S_NB_CHK:
                if (stk_we)
                begin
                    top_next = '{r: part_rdata.r, c: part_rdata.c, idx: part_rdata.idx,
                                 dir: DIR_RIGHT};
                    sp_next  = sp_reg + SPW'(1);
                end
            S_POP:
                top_next = stk_rdata;
            S_FLIP:
                if (sp_reg == SPW'(1))
                    match_next = match_reg + IW'(1);
                else
                    sp_next = sp_reg - SPW'(1);
            S_FLIP_WAIT:
            begin
                top_next   = stk_rdata;
                v_idx_next = flip_idx;
            end
            S_ADV:
            begin
                u_next = u_reg + IW'(1);
                if ((DCW'(uc_reg) + DCW'(1)) == cols_reg)
                begin
                    uc_next = '0;
                    ur_next = ur_reg + RW'(1);
                end
                else
                    uc_next = uc_reg + CW'(1);
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                out_data_next.matching_size    = 10'(match_reg);
                out_data_next.independent_size = 11'(free_count_reg - match_reg);
                load_pos_next   = '0;
                free_count_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            grid_rows_reg  <= DIM_RESET;
            grid_cols_reg  <= DIM_RESET;
            load_pos_reg   <= '0;
            free_count_reg <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            grid_rows_reg  <= grid_rows_next;
            grid_cols_reg  <= grid_cols_next;
            load_pos_reg   <= load_pos_next;
            free_count_reg <= free_count_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        total_reg    <= total_next;
        clr_reg      <= clr_next;
        u_reg        <= u_next;
        ur_reg       <= ur_next;
        uc_reg       <= uc_next;
        root_reg     <= root_next;
        top_reg      <= top_next;
        v_idx_reg    <= v_idx_next;
        match_reg    <= match_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_waddr] <= in_data.cell_free;
        free_rdata <= free_mem[free_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (part_we)
            part_mem[part_waddr] <= part_wdata;
        part_rdata <= part_mem[nb_idx];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rdata <= vis_mem[nb_idx];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= top_reg;
        stk_rdata <= stk_mem[stk_raddr];
    end

endmodule

### hw/rtl/gbmm_checker.sv
module gbmm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input gbmm_pkg::in_t                   in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input gbmm_pkg::out_t                  out_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import gbmm_pkg::*;

    // a finished grid makes the block busy right away
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.last_cell |=> in_stall)
        else $error("input accepted right after last cell");

    // a result only appears at the end of a busy run
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a preceding run");

    // a waiting result blocks the next cell
    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind grid_bipartite_max_matching_unit gbmm_checker u_gbmm_checker (.*);

### test/grid_bipartite_max_matching_unit_tb.sv
module grid_bipartite_max_matching_unit_tb;
    import gbmm_pkg::*;

    localparam int MAX_R = 32;
    localparam int MAX_C = 32;
    localparam int CELLS = MAX_R * MAX_C;
    localparam int NO_PARTNER = -1;

    // expected totals per finished grid, checked in order
    class matching_scoreboard;
        int             grid_rows_reg;
        int             grid_cols_reg;
        bit             cell_map[CELLS];
        int             load_pos;
        int             free_total;
        out_t           pending[$];
        int             mismatches;
        int             results_seen;
        int             partner[CELLS];
        bit             seen_cell[CELLS];
        int             frame_cell[CELLS];
        int             frame_dir[CELLS];

        function new();
            grid_rows_reg = 32;
            grid_cols_reg = 32;
            load_pos = 0;
            free_total = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (cell_map[i]) cell_map[i] = 0;
        endfunction

        function int dim_of(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int step_to(int u, int d, int rows, int cols);
            int r;
            int c;
            r = u / cols;
            c = u % cols;
            case (d)
                DIR_RIGHT: c = c + 1;
                DIR_LEFT:  c = c - 1;
                DIR_DOWN:  r = r + 1;
                DIR_UP:    r = r - 1;
                default:   return NO_PARTNER;
            endcase
            if (r < 0 || c < 0 || r >= rows || c >= cols) return NO_PARTNER;
            if (!cell_map[r * cols + c]) return NO_PARTNER;
            return r * cols + c;
        endfunction

        function bit try_augment(int root, int rows, int cols);
            int sp;
            int u;
            int d;
            int v;
            int w;
            frame_cell[0] = root;
            frame_dir[0] = 0;
            sp = 1;
            while (sp > 0) begin
                u = frame_cell[sp-1];
                d = frame_dir[sp-1];
                if (d >= 4) begin
                    sp--;
                    continue;
                end
                frame_dir[sp-1] = d + 1;
                v = step_to(u, d, rows, cols);
                if (v == NO_PARTNER || seen_cell[v]) continue;
                seen_cell[v] = 1;
                if (partner[v] == NO_PARTNER) begin
                    for (int k = sp; k > 0; k--) begin
                        w = step_to(frame_cell[k-1], frame_dir[k-1] - 1, rows, cols);
                        if (w != NO_PARTNER) partner[w] = frame_cell[k-1];
                    end
                    return 1;
                end
                if (sp < CELLS / 2 + 1) begin
                    frame_cell[sp] = partner[v];
                    frame_dir[sp] = 0;
                    sp++;
                end
            end
            return 0;
        endfunction

        function void note_cell(in_t item);
            int rows;
            int cols;
            int count;
            out_t res;
            rows = dim_of(grid_rows_reg, MAX_R);
            cols = dim_of(grid_cols_reg, MAX_C);
            if (load_pos < rows * cols) begin
                cell_map[load_pos] = item.cell_free;
                if (item.cell_free) free_total++;
                load_pos++;
            end
            if (!item.last_cell) return;
            count = 0;
            foreach (partner[i]) partner[i] = NO_PARTNER;
            for (int u = 0; u < rows * cols; u++) begin
                if (!cell_map[u] || (((u / cols) + (u % cols)) % 2) == 0) continue;
                foreach (seen_cell[i]) seen_cell[i] = 0;
                if (try_augment(u, rows, cols)) count++;
            end
            res.matching_size = count[9:0];
            res.independent_size = 11'(free_total - count);
            pending.insert(pending.size(), res);
            foreach (cell_map[i]) cell_map[i] = 0;
            load_pos = 0;
            free_total = 0;
        endfunction

        function void check_totals(out_t got);
            out_t exp_res;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d/%0d",
                    got.matching_size, got.independent_size);
                return;
            end
            exp_res = pending.pop_front();
            if (got.matching_size !== exp_res.matching_size ||
                got.independent_size !== exp_res.independent_size) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected match %0d indep %0d, got %0d %0d",
                        exp_res.matching_size, exp_res.independent_size,
                        got.matching_size, got.independent_size);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    matching_scoreboard board;
    int  cells_sent;
    int  grids_sent;

    grid_bipartite_max_matching_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // valid stays up into the next call so back to back cells need no gap
    task automatic send_cell(bit free_bit, bit last_bit);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data.cell_free <= free_bit;
        in_data.last_cell <= last_bit;
        do @(posedge clk); while (in_stall);
        board.note_cell('{cell_free: free_bit, last_cell: last_bit});
        cells_sent++;
        if (last_bit) grids_sent++;
        @(negedge clk);
    endtask

    task automatic write_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_GRID_ROWS) board.grid_rows_reg = val;
        else board.grid_cols_reg = val;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // waits for outstanding results, then for the clear pass and search tail
    task automatic drain_run();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (CELLS * 12) @(negedge clk);
    endtask

    // one grid of n cells; density picks how many are free
    task automatic send_grid(int n, int density);
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(0, 99) < density, i == n - 1);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_totals(out_data);
    end

    initial begin
        int gap;
        forever begin
            @(negedge clk);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_stall <= 1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 0;
            @(negedge clk);
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    initial begin
        #400000000;
        $display("grid_bipartite_max_matching_unit_tb: FAIL");
        $finish;
    end

    initial begin
        int r;
        int c;
        board = new();
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = REG_GRID_ROWS;
        cfg_data = DIM_RESET;
        cells_sent = 0;
        grids_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: tiny grids, short grids at reset size, extra cells, out-of-range dims
        send_cell(1, 1);
        drain_run();
        write_dim(REG_GRID_ROWS, 6'd2);
        write_dim(REG_GRID_COLS, 6'd2);
        send_grid(4, 100);
        drain_run();
        send_cell(1, 0);
        send_cell(1, 1);                 // grid cut short
        drain_run();
        for (int i = 0; i < 6; i++) send_cell(1, i == 5);   // extra cells ignored
        drain_run();
        write_dim(REG_GRID_ROWS, 6'd0);  // zero acts as one
        write_dim(REG_GRID_COLS, 6'd63); // above max acts as max
        send_grid(32, 100);
        drain_run();
        write_dim(REG_GRID_ROWS, 6'd32);
        write_dim(REG_GRID_COLS, 6'd32);
        for (int i = 0; i < 4; i++) send_cell(0, i == 3);
        drain_run();

        // random: mostly small grids, a large one only early in the run
        while (cells_sent < 1250) begin
            if (cells_sent < 150 && $urandom_range(0, 9) == 0) begin
                r = 32;
                c = $urandom_range(1, 32);
            end else begin
                r = $urandom_range(1, 6);
                c = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 63);
            write_dim(REG_GRID_ROWS, r[5:0]);
            write_dim(REG_GRID_COLS, c[5:0]);
            r = board.dim_of(r & 63, MAX_R);
            c = board.dim_of(c & 63, MAX_C);
            case ($urandom_range(0, 5))
                0: send_grid(r * c - $urandom_range(0, r * c - 1), 70);
                1: send_grid(r * c + $urandom_range(1, 3), 60);
                default: send_grid(r * c, $urandom_range(30, 100));
            endcase
            drain_run();
        end

        drain_run();
        $display("run covered %0d cells in %0d grids, %0d results checked",
            cells_sent, grids_sent, board.results_seen);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("grid_bipartite_max_matching_unit_tb: PASS");
        else
            $display("grid_bipartite_max_matching_unit_tb: FAIL");
        $finish;
    end
endmodule

### grid_bipartite_max_matching_unit.f
hw/rtl/gbmm_pkg.sv
hw/rtl/grid_bipartite_max_matching_unit.sv
hw/rtl/gbmm_checker.sv
test/grid_bipartite_max_matching_unit_tb.sv
